// ===== rtl/fpda_pkg.sv =====
// Shared types and constants of the fixed point to decimal ASCII formatter.
// Stand-alone package, used by every module of the block.
`timescale 1ns / 1ps

package fpda_pkg;

    localparam int WHOLE_W         = 17;
    localparam int FRAC_IN_W       = 16;
    localparam int CFG_W           = 3;
    localparam int DIG_W           = 4;
    localparam int IDX_W           = 4;
    localparam int STEP_W          = 5;
    localparam int MAX_CHARS       = 10;
    localparam int MAX_FRAC_DIGITS = 4;
    localparam int LIMIT_W         = 40;

    localparam logic [CFG_W-1:0] FRAC_DIGITS_RESET = 3'd2;
    localparam logic [DIG_W-1:0] POINT_CODE        = 4'd10;
    localparam logic [7:0]       ASCII_ZERO        = 8'h30;
    localparam logic [7:0]       ASCII_POINT       = 8'h2E;

    typedef enum logic {
        OP_DABBLE,
        OP_TIMES10
    } op_t;

    typedef struct packed {
        logic [WHOLE_W-1:0]   whole_part;
        logic [FRAC_IN_W-1:0] fraction;
    } item_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } chr_t;

    // Character store fill port and emission start, sequencer to emitter
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [DIG_W-1:0] wr_digit;
        logic             start;
        logic [IDX_W-1:0] count;
    } fill_t;

    function automatic longint pow10(input int n);
        longint p;
        p = 1;
        for (int k = 0; k < n; k++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

endpackage

// ===== rtl/fixed_point_to_decimal_ascii.sv =====
// Fixed point to decimal ASCII formatter, top level with the conversion sequencer.
// Instantiates fpda_step_unit and fpda_emit; uses fpda_pkg.
`timescale 1ns / 1ps

// Converts one request (whole part and binary fraction) into ASCII characters, most
// significant first: the whole part without leading zeros (a single '0' for zero,
// saturated at 10^WHOLE_DIGITS-1), then, when frac_digits is nonzero, '.' and that many
// truncated fraction digits (values above four act as four). last_char marks the final
// character, at most ten in all. A request occupies the block from acceptance until its
// last character is in the output register: double-dabble shifts of the whole part, one
// per bit, then its BCD digits are placed one by one in the character store, then '.'
// and one multiply-by-ten per fraction digit in the shared step unit, then one character
// per cycle from the output register while the receiver does not stall.
// The user must write frac_digits through the cfg channel only while the block is idle;
// the block itself does not enforce this.
module fixed_point_to_decimal_ascii #(
    parameter int WHOLE_DIGITS = 5,
    parameter int FRAC_BITS    = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [fpda_pkg::CFG_W-1:0] cfg_data,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  fpda_pkg::item_t            item,
    output logic                       chr_valid,
    input  logic                       chr_ready,
    output fpda_pkg::chr_t             chr
);

    localparam int BCD_W = 4 * WHOLE_DIGITS;
    localparam int ROOM  = fpda_pkg::MAX_CHARS - 1 - WHOLE_DIGITS;
    localparam logic [fpda_pkg::LIMIT_W-1:0] LIMIT =
        fpda_pkg::LIMIT_W'(fpda_pkg::pow10(WHOLE_DIGITS) - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_COPY,
        ST_POINT,
        ST_FRAC,
        ST_EMIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [fpda_pkg::CFG_W-1:0]    frac_digits_reg, frac_digits_next;
    logic [BCD_W-1:0]              bcd_reg, bcd_next;
    logic [fpda_pkg::WHOLE_W-1:0]  bin_reg, bin_next;
    logic [FRAC_BITS-1:0]          frac_reg, frac_next;
    logic [fpda_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [fpda_pkg::CFG_W-1:0]    d_reg, d_next;
    logic [fpda_pkg::IDX_W-1:0]    left_reg, left_next;
    logic                          seen_reg, seen_next;
    logic [fpda_pkg::IDX_W-1:0]    pos_reg, pos_next;
    fpda_pkg::fill_t               fill_reg, fill_next;

    fpda_pkg::op_t                 op;
    logic [BCD_W-1:0]              bcd_step;
    logic [fpda_pkg::WHOLE_W-1:0]  bin_step;
    logic [FRAC_BITS-1:0]          frac_step;
    logic [fpda_pkg::DIG_W-1:0]    digit_step;

    logic [fpda_pkg::WHOLE_W-1:0]  whole_sat;
    logic [fpda_pkg::CFG_W-1:0]    d_eff;
    logic [fpda_pkg::DIG_W-1:0]    top_digit;
    logic                          emit_busy;

    assign op = (state_reg == ST_FRAC) ? fpda_pkg::OP_TIMES10 : fpda_pkg::OP_DABBLE;

    fpda_step_unit #(
        .WHOLE_DIGITS (WHOLE_DIGITS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_step (
        .op        (op),
        .bcd_in    (bcd_reg),
        .bin_in    (bin_reg),
        .frac_in   (frac_reg),
        .bcd_out   (bcd_step),
        .bin_out   (bin_step),
        .frac_out  (frac_step),
        .digit_out (digit_step)
    );

    fpda_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .fill      (fill_reg),
        .busy      (emit_busy),
        .chr_valid (chr_valid),
        .chr_ready (chr_ready),
        .chr       (chr)
    );

    assign cfg_ready  = 1'b1;
    assign item_ready = (state_reg == ST_IDLE);
    assign top_digit  = bcd_reg[BCD_W-1 -: 4];

    always_comb
    begin
        if ({{(fpda_pkg::LIMIT_W - fpda_pkg::WHOLE_W){1'b0}}, item.whole_part} > LIMIT)
            whole_sat = fpda_pkg::WHOLE_W'(LIMIT);
        else
            whole_sat = item.whole_part;

        if (int'(frac_digits_reg) > fpda_pkg::MAX_FRAC_DIGITS)
            d_eff = fpda_pkg::CFG_W'(fpda_pkg::MAX_FRAC_DIGITS);
        else
            d_eff = frac_digits_reg;
        if (int'(d_eff) > ROOM)
            d_eff = fpda_pkg::CFG_W'(ROOM);
    end

    always_comb
    begin
        state_next       = state_reg;
        frac_digits_next = frac_digits_reg;
        bcd_next         = bcd_reg;
        bin_next         = bin_reg;
        frac_next        = frac_reg;
        step_next        = step_reg;
        d_next           = d_reg;
        left_next        = left_reg;
        seen_next        = seen_reg;
        pos_next         = pos_reg;
        fill_next        = '0;

        if (cfg_valid && cfg_ready)
            frac_digits_next = cfg_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    bcd_next   = '0;
                    bin_next   = whole_sat;
                    frac_next  = FRAC_BITS'(item.fraction);
                    d_next     = d_eff;
                    step_next  = '0;
                    left_next  = fpda_pkg::IDX_W'(WHOLE_DIGITS);
                    seen_next  = 1'b0;
                    pos_next   = '0;
                    state_next = ST_DABBLE;
                end
            end
            ST_DABBLE:
            begin
                bcd_next  = bcd_step;
                bin_next  = bin_step;
                step_next = step_reg + 1'b1;
                if (step_reg == fpda_pkg::STEP_W'(fpda_pkg::WHOLE_W - 1))
                    state_next = ST_COPY;
            end
            ST_COPY:
            begin
                // Drop leading zeros, but always keep the last digit
                bcd_next  = bcd_reg << 4;
                left_next = left_reg - 1'b1;
                if (seen_reg || top_digit != '0 || left_reg == 4'd1)
                begin
                    fill_next.wr_en    = 1'b1;
                    fill_next.wr_addr  = pos_reg;
                    fill_next.wr_digit = top_digit;
                    pos_next           = pos_reg + 1'b1;
                    seen_next          = 1'b1;
                end
                if (left_reg == 4'd1)
                begin
                    if (d_reg != '0)
                    begin
                        state_next = ST_POINT;
                    end
                    else
                    begin
                        fill_next.start = 1'b1;
                        fill_next.count = pos_next;
                        state_next      = ST_EMIT;
                    end
                end
            end
            ST_POINT:
            begin
                fill_next.wr_en    = 1'b1;
                fill_next.wr_addr  = pos_reg;
                fill_next.wr_digit = fpda_pkg::POINT_CODE;
                pos_next           = pos_reg + 1'b1;
                state_next         = ST_FRAC;
            end
            ST_FRAC:
            begin
                fill_next.wr_en    = 1'b1;
                fill_next.wr_addr  = pos_reg;
                fill_next.wr_digit = digit_step;
                frac_next          = frac_step;
                pos_next           = pos_reg + 1'b1;
                d_next             = d_reg - 1'b1;
                if (d_reg == 3'd1)
                begin
                    fill_next.start = 1'b1;
                    fill_next.count = pos_next;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Hold until the emitter has taken the last character
                if (!emit_busy && !fill_reg.start)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            frac_digits_reg <= fpda_pkg::FRAC_DIGITS_RESET;
            step_reg        <= '0;
            d_reg           <= '0;
            left_reg        <= '0;
            seen_reg        <= 1'b0;
            pos_reg         <= '0;
            fill_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            frac_digits_reg <= frac_digits_next;
            step_reg        <= step_next;
            d_reg           <= d_next;
            left_reg        <= left_next;
            seen_reg        <= seen_next;
            pos_reg         <= pos_next;
            fill_reg        <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        bin_reg  <= bin_next;
        frac_reg <= frac_next;
    end

endmodule

// ===== rtl/fpda_step_unit.sv =====
// Shared arithmetic step: one double-dabble shift or one multiply-by-ten of the fraction.
// Uses fpda_pkg for the operation code and field widths.
`timescale 1ns / 1ps

module fpda_step_unit #(
    parameter int WHOLE_DIGITS = 5,
    parameter int FRAC_BITS    = 16
) (
    input  fpda_pkg::op_t                op,
    input  logic [4*WHOLE_DIGITS-1:0]    bcd_in,
    input  logic [fpda_pkg::WHOLE_W-1:0] bin_in,
    input  logic [FRAC_BITS-1:0]         frac_in,
    output logic [4*WHOLE_DIGITS-1:0]    bcd_out,
    output logic [fpda_pkg::WHOLE_W-1:0] bin_out,
    output logic [FRAC_BITS-1:0]         frac_out,
    output logic [fpda_pkg::DIG_W-1:0]   digit_out
);

    localparam int BCD_W = 4 * WHOLE_DIGITS;
    localparam int PROD_W = FRAC_BITS + 4;

    logic [BCD_W-1:0]  bcd_adj;
    logic [PROD_W-1:0] frac_ext;
    logic [PROD_W-1:0] prod;

    // Add three to every BCD digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < WHOLE_DIGITS; i++)
        begin
            if (bcd_in[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_in[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_in[4*i +: 4];
        end
    end

    assign frac_ext = PROD_W'(frac_in);
    assign prod     = (frac_ext << 3) + (frac_ext << 1);

    always_comb
    begin
        bcd_out   = bcd_in;
        bin_out   = bin_in;
        frac_out  = frac_in;
        digit_out = '0;
        unique case (op)
            fpda_pkg::OP_DABBLE:
            begin
                bcd_out = {bcd_adj[BCD_W-2:0], bin_in[fpda_pkg::WHOLE_W-1]};
                bin_out = {bin_in[fpda_pkg::WHOLE_W-2:0], 1'b0};
            end
            fpda_pkg::OP_TIMES10:
            begin
                frac_out  = prod[FRAC_BITS-1:0];
                digit_out = prod[PROD_W-1:FRAC_BITS];
            end
            default:
            begin
                bcd_out = bcd_in;
            end
        endcase
    end

endmodule

// ===== rtl/fpda_emit.sv =====
// Character store and output stage: holds the digit codes of one string and sends them
// as ASCII characters, first to last. Uses fpda_pkg for the fill port and result types.
`timescale 1ns / 1ps

module fpda_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  fpda_pkg::fill_t fill,
    output logic            busy,
    output logic            chr_valid,
    input  logic            chr_ready,
    output fpda_pkg::chr_t  chr
);

    logic [fpda_pkg::DIG_W-1:0] store_reg [fpda_pkg::MAX_CHARS];

    logic                       active_reg, active_next;
    logic [fpda_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [fpda_pkg::IDX_W-1:0] count_reg, count_next;
    logic                       valid_reg, valid_next;
    fpda_pkg::chr_t             chr_reg, chr_next;

    logic [fpda_pkg::DIG_W-1:0] digit;
    logic                       load;

    assign digit = store_reg[idx_reg];
    assign load  = active_reg && (!valid_reg || chr_ready);

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        valid_next  = valid_reg;
        chr_next    = chr_reg;
        if (valid_reg && chr_ready)
            valid_next = 1'b0;
        if (fill.start)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            count_next  = fill.count;
        end
        else if (load)
        begin
            valid_next = 1'b1;
            if (digit == fpda_pkg::POINT_CODE)
                chr_next.char_code = fpda_pkg::ASCII_POINT;
            else
                chr_next.char_code = fpda_pkg::ASCII_ZERO + {4'd0, digit};
            chr_next.last_char = (idx_reg + 1'b1 == count_reg);
            if (idx_reg + 1'b1 == count_reg)
            begin
                active_next = 1'b0;
                idx_next    = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            count_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chr_reg <= chr_next;
        if (fill.wr_en)
            store_reg[fill.wr_addr] <= fill.wr_digit;
    end

    assign busy      = active_reg;
    assign chr_valid = valid_reg;
    assign chr       = chr_reg;

endmodule

// ===== dv/testbench.sv =====
// Testbench of fixed_point_to_decimal_ascii: directed and random readings, checked per character.
// Depends on fpda_pkg and the block's RTL; the expected strings come from an in-bench formatter.
`timescale 1ns / 1ps

module testbench;

    localparam int                           WHOLE_DIGITS  = 5;
    localparam int                           FRAC_BITS     = 16;
    localparam logic [fpda_pkg::WHOLE_W-1:0] WHOLE_LIMIT   = 17'd99999;
    localparam int                           QUIET_LIMIT   = 4000;
    localparam int                           TAIL_CYCLES   = 60;
    localparam int                           IDLE_PCT      = 15;

    logic                         clk        = 1'b0;
    logic                         rst_n      = 1'b0;
    logic                         cfg_valid  = 1'b0;
    logic                         cfg_ready;
    logic [fpda_pkg::CFG_W-1:0]   cfg_data   = '0;
    logic                         item_valid = 1'b0;
    logic                         item_ready;
    fpda_pkg::item_t              item       = '0;
    logic                         chr_valid;
    logic                         chr_ready  = 1'b0;
    fpda_pkg::chr_t               chr;

    fpda_pkg::chr_t               expected_chars[$];
    logic [fpda_pkg::CFG_W-1:0]   frac_digits_model = fpda_pkg::FRAC_DIGITS_RESET;
    logic [7:0]                   settings_used     = '0;
    bit                           item_held         = 1'b0;
    int                           idle_pct          = IDLE_PCT;
    int                           items_sent        = 0;
    int                           chars_seen        = 0;
    int                           error_count       = 0;
    int                           quiet_cycles      = 0;

    fixed_point_to_decimal_ascii #(
        .WHOLE_DIGITS (WHOLE_DIGITS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .chr_valid  (chr_valid),
        .chr_ready  (chr_ready),
        .chr        (chr)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Format one reading the way the block should and queue its characters
    task automatic predict_chars(input fpda_pkg::item_t req);
        logic [fpda_pkg::WHOLE_W-1:0] whole;
        logic [63:0]                  scale;
        logic [63:0]                  scaled;
        logic [fpda_pkg::DIG_W-1:0]   codes[$];
        logic [fpda_pkg::DIG_W-1:0]   frac_codes[$];
        int                           d;
        fpda_pkg::chr_t               c;
        whole = (req.whole_part > WHOLE_LIMIT) ? WHOLE_LIMIT : req.whole_part;
        // with five whole digits the ten-character bound never cuts below four
        d = (frac_digits_model > fpda_pkg::MAX_FRAC_DIGITS) ? fpda_pkg::MAX_FRAC_DIGITS
                                                              : int'(frac_digits_model);
        do
        begin
            codes.push_front(fpda_pkg::DIG_W'(whole % 10));
            whole = fpda_pkg::WHOLE_W'(whole / 10);
        end
        while (whole != 0);
        if (d > 0)
        begin
            scale = 1;
            repeat (d) scale = scale * 10;
            scaled = (64'(req.fraction) * scale) >> FRAC_BITS;
            codes.push_back(fpda_pkg::POINT_CODE);
            repeat (d)
            begin
                frac_codes.push_front(fpda_pkg::DIG_W'(scaled % 10));
                scaled = scaled / 10;
            end
            codes = {codes, frac_codes};
        end
        for (int i = 0; i < codes.size(); i++)
        begin
            c.char_code = (codes[i] == fpda_pkg::POINT_CODE)
                          ? fpda_pkg::ASCII_POINT
                          : fpda_pkg::ASCII_ZERO + 8'(codes[i]);
            c.last_char = (i == codes.size() - 1);
            expected_chars.push_back(c);
        end
    endtask

    // Receiver side: random back-pressure
    always @(posedge clk)
    begin
        chr_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && chr_valid && chr_ready)
        begin
            chars_seen++;
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, actual code %h last %b",
                         $time, chr.char_code, chr.last_char);
                error_count++;
            end
            else
            begin
                fpda_pkg::chr_t want;
                want = expected_chars.pop_front();
                if (chr.char_code !== want.char_code)
                begin
                    $display("%0t: char_code mismatch: expected %h, actual %h",
                             $time, want.char_code, chr.char_code);
                    error_count++;
                end
                if (chr.last_char !== want.last_char)
                begin
                    $display("%0t: last_char mismatch: expected %b, actual %b",
                             $time, want.last_char, chr.last_char);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (chr_valid && chr_ready)
                || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: timeout, no handshake in %0d cycles", $time, QUIET_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Lower a held request and let the clock advance so no second update lands in this step
    task automatic drop_item();
        if (item_held)
        begin
            item_valid <= 1'b0;
            item_held = 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_item(input fpda_pkg::item_t req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0)
        begin
            if (item_held)
            begin
                item_valid <= 1'b0;
                item_held = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= req;
        item_held = 1'b1;
        do @(posedge clk); while (!item_ready);
        predict_chars(req);
        items_sent++;
    endtask

    task automatic wait_drained();
        drop_item();
        while (expected_chars.size() != 0) @(posedge clk);
    endtask

    task automatic write_frac_digits(input logic [fpda_pkg::CFG_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        frac_digits_model = value;
        settings_used[value] = 1'b1;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic fpda_pkg::item_t make_item(input int unsigned whole,
                                                  input int unsigned frac);
        fpda_pkg::item_t r;
        r.whole_part = fpda_pkg::WHOLE_W'(whole);
        r.fraction   = fpda_pkg::FRAC_IN_W'(frac);
        return r;
    endfunction

    function automatic fpda_pkg::item_t random_item();
        fpda_pkg::item_t r;
        case ($urandom_range(9))
            0, 1, 2, 3: r.whole_part = fpda_pkg::WHOLE_W'($urandom_range(99));
            4, 5:       r.whole_part = fpda_pkg::WHOLE_W'($urandom_range(9999));
            6, 7, 8:    r.whole_part = fpda_pkg::WHOLE_W'($urandom_range(99999));
            default:    r.whole_part = fpda_pkg::WHOLE_W'($urandom_range(131071, 100000));
        endcase
        case ($urandom_range(7))
            0:       r.fraction = '0;
            1:       r.fraction = '1;
            default: r.fraction = fpda_pkg::FRAC_IN_W'($urandom);
        endcase
        return r;
    endfunction

    // Reset value of the digit count is two
    task automatic test_reset_setting();
        settings_used[fpda_pkg::FRAC_DIGITS_RESET] = 1'b1;
        send_item(make_item(0, 0));
        send_item(make_item(3, 16'h4000));
        send_item(make_item(0, 16'hFFFF));
    endtask

    // Field extremes and whole-part saturation at four fraction digits
    task automatic test_field_extremes();
        write_frac_digits(3'd4);
        send_item(make_item(0, 0));
        send_item(make_item(0, 16'hFFFF));
        send_item(make_item(1, 1));
        send_item(make_item(9, 16'h8000));
        send_item(make_item(10, 16'h199A));
        send_item(make_item(99999, 16'hFFFF));
        send_item(make_item(100000, 0));
        send_item(make_item(131071, 16'hFFFF));
        send_item(make_item(65536, 16'h0001));
        send_item(make_item(54321, 16'hAAAA));
    endtask

    // Every register value, including the ones above four that clamp
    task automatic test_digit_counts();
        for (int v = 0; v < 8; v++)
        begin
            write_frac_digits(fpda_pkg::CFG_W'(v));
            send_item(make_item(12345, 16'hFFFF));
        end
    endtask

    task automatic run_random_phase(input logic [fpda_pkg::CFG_W-1:0] setting,
                                    input int count, input bit pause_midway);
        write_frac_digits(setting);
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
            begin
                wait_drained();
            end
            send_item(random_item());
        end
    endtask

    task automatic test_random_settings();
        run_random_phase(3'd0, 30, 1'b0);
        run_random_phase(3'd4, 30, 1'b1);
        run_random_phase(3'd1, 25, 1'b0);
        run_random_phase(3'd3, 25, 1'b1);
        run_random_phase(fpda_pkg::CFG_W'($urandom_range(7)), 30, 1'b0);
        run_random_phase(fpda_pkg::CFG_W'($urandom_range(7)), 30, 1'b0);
    endtask

    // Long stretch with neither side idling
    task automatic test_back_to_back();
        wait_drained();
        idle_pct = 0;
        run_random_phase(3'd4, 40, 1'b0);
        wait_drained();
        idle_pct = IDLE_PCT;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_setting();
        test_field_extremes();
        test_digit_counts();
        test_random_settings();
        test_back_to_back();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Formatted %0d readings into %0d characters, %0d mismatches.",
                 items_sent, chars_seen, error_count);
        $display("Digit-count settings exercised (bit per value 0..7): %b", settings_used);
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
